@@ rtl/spi_pkg.sv @@
// shared types and constants of the segment / plane intersection block
// no dependencies
package spi_pkg;

  // quotient bits kept by the point divider (clip point is 2^40)
  localparam int QBITS = 41;
  // latency of one point lane, from its input registers to its result
  localparam int DIV_LAT = QBITS + 4;
  // latency of the dot product front end
  localparam int FRONT_LAT = 4;

  localparam logic [2:0] CFG_NORMAL_X = 3'd0;
  localparam logic [2:0] CFG_NORMAL_Y = 3'd1;
  localparam logic [2:0] CFG_NORMAL_Z = 3'd2;
  localparam logic [2:0] CFG_PLANE_X  = 3'd3;
  localparam logic [2:0] CFG_PLANE_Y  = 3'd4;
  localparam logic [2:0] CFG_PLANE_Z  = 3'd5;
  localparam logic [2:0] CFG_LIMIT    = 3'd6;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_NONE     = 2'd1,
    ST_PARALLEL = 2'd2,
    ST_ON_PLANE = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic               unbounded_line;
  } spi_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic               saturated;
  } spi_out_t;

  // classification that travels beside the point lanes
  typedef struct packed {
    status_t status;
    logic    sign_ab;
  } spi_cls_t;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

endpackage

@@ rtl/spi_front.sv @@
// dot product front end: differences, scaled products, sums, classification
// depends on spi_pkg
module spi_front import spi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                adv,
  input  spi_in_t             item,
  input  logic signed [31:0]  normal [3],
  input  logic signed [31:0]  plane [3],
  input  logic [31:0]         limit,
  output spi_cls_t            cls,
  output logic [64-FRAC_BITS:0] ma,
  output logic [64-FRAC_BITS:0] mb,
  output logic signed [32:0]  seg [3],
  output logic signed [31:0]  start [3]
);

  localparam int MW = 65 - FRAC_BITS;
  localparam int DW = MW + 1;

  logic signed [31:0] st_in [3];
  logic signed [31:0] en_in [3];

  assign st_in[0] = item.start_x;
  assign st_in[1] = item.start_y;
  assign st_in[2] = item.start_z;
  assign en_in[0] = item.end_x;
  assign en_in[1] = item.end_y;
  assign en_in[2] = item.end_z;

  // stage a
  logic signed [32:0] seg_a [3];
  logic signed [32:0] rel_a [3];
  logic signed [31:0] st_a [3];
  logic               unb_a;
  // stage b
  logic [MW-1:0]      pa_m [3];
  logic [MW-1:0]      pb_m [3];
  logic               pa_s [3];
  logic               pb_s [3];
  logic signed [32:0] seg_b [3];
  logic signed [31:0] st_b [3];
  logic               unb_b;
  // stage c
  logic signed [DW-1:0] dot_a;
  logic signed [DW-1:0] dot_b;
  logic signed [32:0] seg_c [3];
  logic signed [31:0] st_c [3];
  logic               unb_c;

  logic signed [DW-1:0] sum_a, sum_b;
  logic [MW-1:0]      ma_next, mb_next;
  logic [MW-1:0]      lim;
  spi_cls_t           cls_next;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        seg_a[i] <= 33'(en_in[i]) - 33'(st_in[i]);
        rel_a[i] <= 33'(plane[i]) - 33'(st_in[i]);
        st_a[i]  <= st_in[i];
      end
      unb_a <= item.unbounded_line;
    end
  end

  always_ff @(posedge clk) begin
    logic [65:0] prod_a, prod_b;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod_a = mag33(seg_a[i]) * mag33(33'(normal[i]));
        prod_b = mag33(rel_a[i]) * mag33(33'(normal[i]));
        pa_m[i]  <= prod_a[FRAC_BITS +: MW];
        pb_m[i]  <= prod_b[FRAC_BITS +: MW];
        pa_s[i]  <= seg_a[i][32] ^ normal[i][31];
        pb_s[i]  <= rel_a[i][32] ^ normal[i][31];
        seg_b[i] <= seg_a[i];
        st_b[i]  <= st_a[i];
      end
      unb_b <= unb_a;
    end
  end

  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int i = 0; i < 3; i++) begin
      sum_a = sum_a + (pa_s[i] ? -$signed(DW'(pa_m[i])) : $signed(DW'(pa_m[i])));
      sum_b = sum_b + (pb_s[i] ? -$signed(DW'(pb_m[i])) : $signed(DW'(pb_m[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot_a <= sum_a;
      dot_b <= sum_b;
      seg_c <= seg_b;
      st_c  <= st_b;
      unb_c <= unb_b;
    end
  end

  always_comb begin
    ma_next = dot_a[DW-1] ? MW'(-dot_a) : MW'(dot_a);
    mb_next = dot_b[DW-1] ? MW'(-dot_b) : MW'(dot_b);
    lim     = MW'(limit);
    cls_next.sign_ab = dot_a[DW-1] ^ dot_b[DW-1];
    if (ma_next <= lim) begin
      cls_next.status = (mb_next <= lim) ? ST_ON_PLANE : ST_PARALLEL;
    end else if (!unb_c && dot_b != '0 && (cls_next.sign_ab || mb_next > ma_next)) begin
      cls_next.status = ST_NONE;
    end else begin
      cls_next.status = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma    <= ma_next;
      mb    <= mb_next;
      cls   <= cls_next;
      seg   <= seg_c;
      start <= st_c;
    end
  end

endmodule

@@ rtl/spi_lane.sv @@
// one axis of the hit point: product, pipelined restoring divide, saturating add
// depends on spi_pkg
module spi_lane import spi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic signed [32:0]    seg,
  input  logic signed [31:0]    start,
  input  logic [64-FRAC_BITS:0] ma,
  input  logic [64-FRAC_BITS:0] mb,
  input  logic                  sign_ab,
  output logic signed [31:0]    hit,
  output logic                  sat
);

  localparam int MW = 65 - FRAC_BITS;
  localparam int HW = (MW + 1) / 2;
  localparam int NW = 33 + MW;
  localparam int RW = MW + QBITS;

  // stage e: split product
  logic [33+HW-1:0] p_lo, p_hi;
  logic [MW-1:0]    ma_e;
  logic signed [31:0] st_e;
  logic             neg_e;
  // stage f: full numerator
  logic [NW-1:0]    num_f;
  logic [MW-1:0]    ma_f;
  logic signed [31:0] st_f;
  logic             neg_f;

  // divider stages, index 0 is the overflow check output
  logic [RW-1:0]    rem_s [QBITS];
  logic [MW-1:0]    ma_s [QBITS];
  logic [QBITS-1:0] q_s [QBITS+1];
  logic             ovf_s [QBITS+1];
  logic             neg_s [QBITS+1];
  logic signed [31:0] st_s [QBITS+1];

  always_ff @(posedge clk) begin
    logic [32:0] smag;
    if (adv) begin
      smag  = mag33(seg);
      p_lo  <= (33+HW)'(smag * HW'(mb));
      p_hi  <= (33+HW)'(smag * HW'(mb >> HW));
      ma_e  <= ma;
      st_e  <= start;
      neg_e <= seg[32] ^ sign_ab;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_f <= NW'(p_lo) + (NW'(p_hi) << HW);
      ma_f  <= ma_e;
      st_f  <= st_e;
      neg_f <= neg_e;
    end
  end

  // quotient of 2^41 or more is clipped anyway
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_s[0] <= RW'(num_f);
      ovf_s[0] <= RW'(num_f) >= (RW'(ma_f) << QBITS);
      ma_s[0]  <= ma_f;
      q_s[0]   <= '0;
      neg_s[0] <= neg_f;
      st_s[0]  <= st_f;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    localparam int BP = QBITS - 1 - k;
    logic [RW-1:0] trial;
    logic          take;
    assign trial = RW'(ma_s[k]) << BP;
    assign take  = rem_s[k] >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        q_s[k+1]   <= take ? (q_s[k] | (QBITS'(1) << BP)) : q_s[k];
        ovf_s[k+1] <= ovf_s[k];
        neg_s[k+1] <= neg_s[k];
        st_s[k+1]  <= st_s[k];
      end
    end

    // the last step needs no remainder
    if (k < QBITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_s[k+1] <= take ? rem_s[k] - trial : rem_s[k];
          ma_s[k+1]  <= ma_s[k];
        end
      end
    end
  end

  localparam logic [QBITS-1:0] QMAX = QBITS'(1) << (QBITS - 1);

  logic [QBITS-1:0]   qm;
  logic signed [QBITS+1:0] sum;

  always_comb begin
    qm  = (ovf_s[QBITS] || q_s[QBITS] > QMAX) ? QMAX : q_s[QBITS];
    sum = (QBITS+2)'(st_s[QBITS]) +
          (neg_s[QBITS] ? -$signed((QBITS+2)'(qm)) : $signed((QBITS+2)'(qm)));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sum > (QBITS+2)'(32'sh7FFF_FFFF)) begin
        hit <= 32'sh7FFF_FFFF;
        sat <= 1'b1;
      end else if (sum < (QBITS+2)'(-33'sh0_8000_0000)) begin
        hit <= 32'sh8000_0000;
        sat <= 1'b1;
      end else begin
        hit <= 32'(sum);
        sat <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/segment_plane_intersect.sv @@
// top level of the segment / plane intersection block
// depends on spi_pkg, spi_front, spi_lane
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------
//  in       | sink      | in_valid / in_stall    | in_item  (spi_in_t)
//  out      | source    | out_valid / out_stall  | out_item (spi_out_t)
//  cfg      | sink      | cfg_write              | cfg_index, cfg_data
//
// one item per cycle while no result is held; each item passes the front end,
// then an axis lane with its 41 one-bit divider steps, and the output register
// rst is synchronous; it clears the valid chain and sets the plane to z = 0
// a held result stalls the whole pipeline in place; bubbles still move
// when the output register is empty
module segment_plane_intersect import spi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  spi_in_t     in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output spi_out_t    out_item,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int MW  = 65 - FRAC_BITS;
  localparam int TOT = FRONT_LAT + DIV_LAT;

  logic               adv;
  logic signed [31:0] normal [3];
  logic signed [31:0] plane [3];
  logic [31:0]        limit;
  logic [TOT-1:0]     vld;

  spi_cls_t           cls;
  spi_cls_t           cls_d [DIV_LAT];
  logic [MW-1:0]      ma, mb;
  logic signed [32:0] seg [3];
  logic signed [31:0] start [3];
  logic signed [31:0] hit [3];
  logic               sat [3];

  // whole pipeline moves unless a result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // plane registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal[0] <= '0;
      normal[1] <= '0;
      normal[2] <= 32'sd65536;
      plane[0]  <= '0;
      plane[1]  <= '0;
      plane[2]  <= '0;
      limit     <= 32'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NORMAL_X: normal[0] <= cfg_data;
        CFG_NORMAL_Y: normal[1] <= cfg_data;
        CFG_NORMAL_Z: normal[2] <= cfg_data;
        CFG_PLANE_X:  plane[0]  <= cfg_data;
        CFG_PLANE_Y:  plane[1]  <= cfg_data;
        CFG_PLANE_Z:  plane[2]  <= cfg_data;
        CFG_LIMIT:    limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid chain alongside the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[TOT-2:0], in_valid};
      out_valid <= vld[TOT-1];
    end
  end

  spi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .adv    (adv),
    .item   (in_item),
    .normal (normal),
    .plane  (plane),
    .limit  (limit),
    .cls    (cls),
    .ma     (ma),
    .mb     (mb),
    .seg    (seg),
    .start  (start)
  );

  for (genvar a = 0; a < 3; a++) begin : g_lane
    spi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .adv     (adv),
      .seg     (seg[a]),
      .start   (start[a]),
      .ma      (ma),
      .mb      (mb),
      .sign_ab (cls.sign_ab),
      .hit     (hit[a]),
      .sat     (sat[a])
    );
  end

  // classification waits for the lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      cls_d[0] <= cls;
      for (int k = 1; k < DIV_LAT; k++) begin
        cls_d[k] <= cls_d[k-1];
      end
    end
  end

  // output register, point forced to zero unless there is a hit
  always_ff @(posedge clk) begin
    logic hit_ok;
    if (adv) begin
      hit_ok = cls_d[DIV_LAT-1].status == ST_HIT;
      out_item.status    <= cls_d[DIV_LAT-1].status;
      out_item.hit_x     <= hit_ok ? hit[0] : '0;
      out_item.hit_y     <= hit_ok ? hit[1] : '0;
      out_item.hit_z     <= hit_ok ? hit[2] : '0;
      out_item.saturated <= hit_ok && (sat[0] || sat[1] || sat[2]);
    end
  end

endmodule

@@ tb/sv/segment_plane_intersect_test.sv @@
`timescale 1ns / 100ps
// testbench of segment_plane_intersect: directed and random segments against several planes
// depends on spi_pkg and the segment_plane_intersect rtl
module segment_plane_intersect_test;
  import spi_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = FRONT_LAT + DIV_LAT + 10;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  spi_in_t     in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  spi_out_t    out_item;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = CFG_NORMAL_X;
  logic [31:0] cfg_data = '0;

  // plane as the testbench believes it to be
  logic signed [31:0] plane_normal [3];
  logic signed [31:0] plane_point [3];
  logic [31:0]        near_zero;

  spi_out_t hits_due [$];
  int       errors = 0;
  int       cycles = 0;
  int       status_seen [4] = '{0, 0, 0, 0};
  int       clipped_seen = 0;
  bit       no_gaps = 1'b0;
  int       stall_left = 0;

  segment_plane_intersect #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // magnitude of a signed value as an unsigned 64-bit vector
  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // fixed point product, magnitude truncated toward zero, sign put back
  function automatic longint scaled_product(longint a, longint b);
    logic [63:0] m;
    m = (magnitude(a) * magnitude(b)) >> FRAC;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // expected result for one segment under the current plane
  function automatic spi_out_t intersect_plane(spi_in_t it);
    longint      st [3];
    longint      en [3];
    longint      seg [3];
    longint      dot_a;
    longint      dot_b;
    longint      v;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [127:0] q;
    logic [63:0] qm;
    bit          neg;
    spi_out_t    r;
    dot_a = 0;
    dot_b = 0;
    r = '0;
    st[0] = longint'(it.start_x); st[1] = longint'(it.start_y); st[2] = longint'(it.start_z);
    en[0] = longint'(it.end_x);   en[1] = longint'(it.end_y);   en[2] = longint'(it.end_z);
    for (int i = 0; i < 3; i++) begin
      seg[i] = en[i] - st[i];
      dot_a += scaled_product(seg[i], longint'(plane_normal[i]));
      dot_b += scaled_product(longint'(plane_point[i]) - st[i], longint'(plane_normal[i]));
    end
    ma = magnitude(dot_a);
    mb = magnitude(dot_b);
    if (ma <= {32'd0, near_zero}) begin
      r.status = (mb <= {32'd0, near_zero}) ? ST_ON_PLANE : ST_PARALLEL;
    end else if (!it.unbounded_line && dot_b != 0 &&
                 (((dot_a < 0) != (dot_b < 0)) || mb > ma)) begin
      r.status = ST_NONE;
    end else begin
      r.status = ST_HIT;
      for (int i = 0; i < 3; i++) begin
        q = (128'(magnitude(seg[i])) * 128'(mb)) / 128'(ma);
        qm = (q > (128'd1 << 40)) ? (64'd1 << 40) : q[63:0];
        neg = (seg[i] < 0) != (dot_b < 0);
        if (dot_a < 0) neg = !neg;
        v = st[i] + (neg ? -longint'(qm) : longint'(qm));
        if (v > 64'sh7FFFFFFF) begin
          v = 64'sh7FFFFFFF;
          r.saturated = 1'b1;
        end
        if (v < -64'sh80000000) begin
          v = -64'sh80000000;
          r.saturated = 1'b1;
        end
        case (i)
          0: r.hit_x = v[31:0];
          1: r.hit_y = v[31:0];
          default: r.hit_z = v[31:0];
        endcase
      end
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return 32'hFFFFFFFF;
          default: return 32'h0;
        endcase
      end
      2, 3, 4, 5: return $urandom_range(0, 32'h00200000) - 32'h00100000;
      default: return $urandom_range(0, 32'h20000000) - 32'h10000000;
    endcase
  endfunction

  function automatic spi_in_t pick_segment();
    spi_in_t it;
    it.start_x = pick_coord(); it.start_y = pick_coord(); it.start_z = pick_coord();
    it.end_x = pick_coord();   it.end_y = pick_coord();   it.end_z = pick_coord();
    it.unbounded_line = 1'($urandom_range(0, 1));
    // degenerate segment now and then: exercises parallel and on-plane
    if ($urandom_range(0, 9) == 0) begin
      it.end_x = it.start_x; it.end_y = it.start_y; it.end_z = it.start_z;
    end
    return it;
  endfunction

  // receiver stall pattern, changed at the falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_stall = stall_left > 0;
    end else begin
      out_stall = 1'b0;
    end
  end

  // result checker: oldest expectation against each accepted result
  always @(posedge clk) begin
    spi_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (hits_due.size() == 0) begin
        $error("result with nothing expected: %h", out_item);
        errors++;
      end else begin
        want = hits_due.pop_front();
        status_seen[out_item.status]++;
        if (out_item.saturated) clipped_seen++;
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          errors++;
        end
        if (out_item.hit_x !== want.hit_x) begin
          $error("hit_x: expected %h, got %h", want.hit_x, out_item.hit_x);
          errors++;
        end
        if (out_item.hit_y !== want.hit_y) begin
          $error("hit_y: expected %h, got %h", want.hit_y, out_item.hit_y);
          errors++;
        end
        if (out_item.hit_z !== want.hit_z) begin
          $error("hit_z: expected %h, got %h", want.hit_z, out_item.hit_z);
          errors++;
        end
        if (out_item.saturated !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated, out_item.saturated);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_plane_intersect verification failed");
      $finish;
    end
  end

  // send one segment; valid stays up afterwards unless the next gap drops it
  task automatic send_segment(spi_in_t it);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    hits_due.push_back(intersect_plane(it));
    @(negedge clk);
  endtask

  // stop sending and let every expected result come out
  task automatic drain_block();
    in_valid = 1'b0;
    while (hits_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_NORMAL_X: plane_normal[0] = val;
      CFG_NORMAL_Y: plane_normal[1] = val;
      CFG_NORMAL_Z: plane_normal[2] = val;
      CFG_PLANE_X:  plane_point[0] = val;
      CFG_PLANE_Y:  plane_point[1] = val;
      CFG_PLANE_Z:  plane_point[2] = val;
      default:      near_zero = val;
    endcase
  endtask

  task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [31:0] eps);
    drain_block();
    write_reg(CFG_NORMAL_X, nx);
    write_reg(CFG_NORMAL_Y, ny);
    write_reg(CFG_NORMAL_Z, nz);
    write_reg(CFG_PLANE_X, px);
    write_reg(CFG_PLANE_Y, py);
    write_reg(CFG_PLANE_Z, pz);
    write_reg(CFG_LIMIT, eps);
  endtask

  function automatic spi_in_t make_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                           logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                                           logic ub);
    spi_in_t it;
    it.start_x = sx; it.start_y = sy; it.start_z = sz;
    it.end_x = ex;   it.end_y = ey;   it.end_z = ez;
    it.unbounded_line = ub;
    return it;
  endfunction

  // reset plane z = 0: crossing, miss, parallel, on plane, line beyond the ends
  task automatic test_reset_plane();
    send_segment(make_segment(32'h10000, 32'h20000, 32'hFFFF0000,
                              32'h30000, 32'h40000, 32'h10000, 1'b0));
    send_segment(make_segment(0, 0, 32'h10000, 0, 0, 32'h20000, 1'b0));
    send_segment(make_segment(0, 0, 32'h10000, 0, 0, 32'h20000, 1'b1));
    send_segment(make_segment(0, 0, 32'h10000, 32'h50000, 0, 32'h10000, 1'b0));
    send_segment(make_segment(0, 0, 0, 32'h50000, 32'h30000, 0, 1'b0));
    // ending exactly on the plane: t of one and of zero
    send_segment(make_segment(0, 0, 32'h10000, 32'h10000, 0, 0, 1'b0));
    send_segment(make_segment(0, 0, 0, 32'h10000, 0, 32'h10000, 1'b0));
  endtask

  // field extremes and a clipped point
  task automatic test_extremes();
    send_segment(make_segment(32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0));
    send_segment(make_segment(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1));
    // tiny step along z on a huge x spread: far point on the infinite line
    send_segment(make_segment(32'h7FFF0000, 0, 32'h10000, 32'h80000000, 0, 32'h0FFFF,
                              1'b1));
    send_segment(make_segment(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                              32'h0, 32'h0, 32'h0, 1'b0));
  endtask

  // zero epsilon, full-scale normals and the largest epsilon
  task automatic test_odd_planes();
    set_plane(32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 0, 32'h0);
    send_segment(make_segment(0, 0, 0, 32'h10000, 32'hFFFF0000, 0, 1'b0));
    send_segment(make_segment(32'h10000, 0, 0, 32'h10000, 32'h10000, 32'hFFFF0000, 1'b1));
    send_segment(make_segment(0, 0, 0, 32'h30000, 0, 0, 1'b0));
    set_plane(32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0);
    send_segment(make_segment(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0, 1'b1));
    send_segment(make_segment(0, 32'h7FFFFFFF, 0, 0, 32'h80000000, 32'h10000, 1'b0));
    set_plane(32'h10000, 0, 0, 0, 0, 0, 32'hFFFFFFFF);
    send_segment(make_segment(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0, 1'b0));
    send_segment(pick_segment());
  endtask

  // random segments against a random plane, one pause to empty the pipeline
  task automatic test_random_plane(int count, logic [31:0] eps);
    set_plane(pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord(), eps);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain_block();
      if (n % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_segment(pick_segment());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    plane_normal = '{32'sd0, 32'sd0, 32'sd65536};
    plane_point = '{32'sd0, 32'sd0, 32'sd0};
    near_zero = 32'd1;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_reset_plane();
    test_extremes();
    test_odd_planes();
    for (int p = 0; p < 10; p++) begin
      test_random_plane(140, (p % 3 == 0) ? 32'd0 : $urandom_range(0, 32'h400));
    end
    drain_block();
    $display("covered hits %0d, misses %0d, parallel %0d, on plane %0d, clipped %0d",
             status_seen[ST_HIT], status_seen[ST_NONE], status_seen[ST_PARALLEL],
             status_seen[ST_ON_PLANE], clipped_seen);
    $display("fourteen planes, zero and full epsilon, random gaps and stalls on both sides");
    if (errors == 0) begin
      $display("segment_plane_intersect verification clean");
    end else begin
      $display("segment_plane_intersect verification failed");
    end
    $finish;
  end

endmodule
